FILE: design/periodic_callback_timer_bank_unit_assert.svh
// Assertion macros shared by the timer bank checker.
// Expects clk and rst_n in the scope where they are used.
`ifndef PERIODIC_CALLBACK_TIMER_BANK_UNIT_ASSERT_SVH
`define PERIODIC_CALLBACK_TIMER_BANK_UNIT_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define PTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: design/ptb_pkg.sv
// Package for the periodic timer bank: sizes, codes and the entry type.
// No dependencies.
`default_nettype none

package ptb_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_REG   = 2'd1,
    FUNC_UNREG = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_FIRE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_REG   = 2'd2,
    KIND_UNREG = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRD,
    ST_TEV,
    ST_TSUM,
    ST_REG,
    ST_URD,
    ST_UEV,
    ST_USHIFT,
    ST_USWR,
    ST_UOUT
  } state_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] period;
    logic [31:0] elapsed;
  } entry_t;

endpackage

`default_nettype wire

FILE: design/periodic_callback_timer_bank_unit.sv
// Periodic timer bank top level: sequencer, entry memory and output register.
// Depends on ptb_pkg.
`default_nettype none

// One item at a time: the next word is taken once the sequencer is back in idle,
// after any walk over the entry memory (one read, one write a cycle) and the
// result word; the sequencer waits while the output is stalled and a word must go out.
// Reset (rst_n low, synchronous): sequencer idle, entry count, tick and uptime
// totals cleared, ms_per_tick set to 1, output word dropped; entries are
// left as they are.
module periodic_callback_timer_bank_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [9:0]                  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_func,
  input  wire logic [15:0]                 in_handle,
  input  wire logic [31:0]                 in_interval_ms,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_kind,
  output logic [ptb_pkg::SLOT_W-1:0]       out_slot,
  output logic [15:0]                      out_fired_handle,
  output logic                             out_ok,
  output logic [63:0]                      out_tick_total,
  output logic [63:0]                      out_uptime_total_ms,
  output logic [ptb_pkg::CNT_W-1:0]        out_active_entries,
  output logic                             out_last
);
  import ptb_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [63:0]        tick_r, tick_nxt;
  logic [63:0]        up_r, up_nxt;
  logic [9:0]         ms_r;
  logic [15:0]        h_r, h_nxt;
  logic [31:0]        iv_r, iv_nxt;
  logic [SLOT_W-1:0]  hit_r, hit_nxt;
  logic               found_r, found_nxt;

  entry_t             mem [SLOTS];
  entry_t             rd_r;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  entry_t             mem_wdata;
  logic [SLOT_W-1:0]  mem_raddr;

  logic               out_valid_r, out_free;
  kind_t              out_kind_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [15:0]        out_handle_r;
  logic               out_ok_r, out_last_r;
  logic [63:0]        out_tick_r, out_up_r;
  logic [CNT_W-1:0]   out_act_r;

  logic               ld;
  kind_t              ld_kind;
  logic [SLOT_W-1:0]  ld_slot;
  logic [15:0]        ld_handle;
  logic               ld_ok, ld_last;
  logic [CNT_W-1:0]   ld_act;

  logic [32:0]        sum;
  logic [31:0]        c_sat;
  logic               fire;
  logic [CNT_W-1:0]   idx_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign idx_inc  = idx_r + CNT_W'(1);

  // shared saturating add and compare for the tick walk
  assign sum   = {1'b0, rd_r.elapsed} + {23'd0, ms_r};
  assign c_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign fire  = (c_sat >= rd_r.period);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    tick_nxt  = tick_r;
    up_nxt    = up_r;
    h_nxt     = h_r;
    iv_nxt    = iv_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[SLOT_W-1:0];
    mem_wdata = rd_r;
    mem_raddr = idx_r[SLOT_W-1:0];
    ld        = 1'b0;
    ld_kind   = KIND_TICK;
    ld_slot   = '0;
    ld_handle = '0;
    ld_ok     = 1'b0;
    ld_last   = 1'b0;
    ld_act    = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          h_nxt     = in_handle;
          iv_nxt    = in_interval_ms;
          idx_nxt   = '0;
          hit_nxt   = '0;
          found_nxt = 1'b0;
          case (in_func)
            FUNC_TICK: begin
              tick_nxt  = tick_r + 64'd1;
              up_nxt    = up_r + {54'd0, ms_r};
              state_nxt = (cnt_r == '0) ? ST_TSUM : ST_TRD;
            end
            FUNC_REG:   state_nxt = ST_REG;
            FUNC_UNREG: state_nxt = (cnt_r == '0) ? ST_UOUT : ST_URD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TRD: state_nxt = ST_TEV;
      ST_TEV: begin
        // hold until the fire word can go out
        if (!(fire && rd_r.handle != '0) || out_free) begin
          ld        = fire && (rd_r.handle != '0);
          ld_kind   = KIND_FIRE;
          ld_slot   = idx_r[SLOT_W-1:0];
          ld_handle = rd_r.handle;
          mem_we    = 1'b1;
          mem_wdata = rd_r;
          mem_wdata.elapsed = fire ? 32'd0 : c_sat;
          idx_nxt   = idx_inc;
          state_nxt = (idx_inc == cnt_r) ? ST_TSUM : ST_TRD;
        end
      end
      ST_TSUM: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_TICK;
          ld_last   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REG: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_REG;
          ld_handle = h_r;
          ld_last   = 1'b1;
          if (cnt_r < CNT_W'(SLOTS)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[SLOT_W-1:0];
            mem_wdata = '{handle: h_r, period: iv_r, elapsed: 32'd0};
            cnt_nxt   = cnt_r + CNT_W'(1);
            ld_slot   = cnt_r[SLOT_W-1:0];
            ld_ok     = 1'b1;
            ld_act    = cnt_r + CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_URD: state_nxt = ST_UEV;
      ST_UEV: begin
        if (rd_r.handle == h_r) begin
          hit_nxt   = idx_r[SLOT_W-1:0];
          found_nxt = 1'b1;
          state_nxt = ST_USHIFT;
        end else if (idx_inc == cnt_r) begin
          state_nxt = ST_UOUT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_URD;
        end
      end
      ST_USHIFT: begin
        // close the gap: move entry idx+1 down to idx
        mem_raddr = idx_inc[SLOT_W-1:0];
        state_nxt = (idx_inc < cnt_r) ? ST_USWR : ST_UOUT;
      end
      ST_USWR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_r;
        idx_nxt   = idx_inc;
        state_nxt = ST_USHIFT;
      end
      ST_UOUT: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_UNREG;
          ld_slot   = hit_r;
          ld_handle = h_r;
          ld_ok     = found_r;
          ld_last   = 1'b1;
          cnt_nxt   = found_r ? cnt_r - CNT_W'(1) : cnt_r;
          ld_act    = cnt_nxt;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tick_r      <= '0;
      up_r        <= '0;
      ms_r        <= 10'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      up_r        <= up_nxt;
      if (cfg_we) begin
        ms_r <= cfg_wdata;
      end
      out_valid_r <= ld || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    h_r     <= h_nxt;
    iv_r    <= iv_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    if (ld) begin
      out_kind_r   <= ld_kind;
      out_slot_r   <= ld_slot;
      out_handle_r <= ld_handle;
      out_ok_r     <= ld_ok;
      out_last_r   <= ld_last;
      out_tick_r   <= tick_r;
      out_up_r     <= up_r;
      out_act_r    <= ld_act;
    end
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= mem[mem_raddr];
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_slot            = out_slot_r;
  assign out_fired_handle    = out_handle_r;
  assign out_ok              = out_ok_r;
  assign out_tick_total      = out_tick_r;
  assign out_uptime_total_ms = out_up_r;
  assign out_active_entries  = out_act_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

FILE: design/ptb_checker.sv
// Port-level checks for the periodic timer bank, bound to the top level.
// Depends on ptb_pkg and periodic_callback_timer_bank_unit_assert.svh.
`default_nettype none

`include "periodic_callback_timer_bank_unit_assert.svh"

module ptb_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [1:0]                 in_func,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [1:0]                 out_kind,
  input wire logic [ptb_pkg::SLOT_W-1:0] out_slot,
  input wire logic                       out_ok,
  input wire logic [ptb_pkg::CNT_W-1:0]  out_active_entries,
  input wire logic                       out_last
);
  import ptb_pkg::*;

  // a stalled word holds
  `PTB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_kind) && $stable(out_slot) && $stable(out_last))

  `PTB_ASSERT_SAME(a_fire_not_last, out_valid && out_kind == KIND_FIRE,
    !out_last && !out_ok)

  `PTB_ASSERT_SAME(a_tick_summary, out_valid && out_kind == KIND_TICK,
    out_last && out_slot == '0 && !out_ok)

  `PTB_ASSERT_SAME(a_count_range, out_valid, out_active_entries <= CNT_W'(SLOTS))

  // a real operation keeps the input side busy afterwards
  `PTB_ASSERT_NEXT(a_busy_after_accept,
    in_valid && !in_stall &&
      (in_func == FUNC_TICK || in_func == FUNC_REG || in_func == FUNC_UNREG),
    in_stall)

endmodule

bind periodic_callback_timer_bank_unit ptb_checker u_ptb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_func            (in_func),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_slot           (out_slot),
  .out_ok             (out_ok),
  .out_active_entries (out_active_entries),
  .out_last           (out_last)
);

`default_nettype wire
